FILE: sv/fhd_pkg.sv
// fhd_pkg: shared constants, word types and control structs of the fir filter unit
// no dependencies; imported by every fhd module except fhd_ram

package fhd_pkg;

	localparam int TAP_COUNT    = 201;
	localparam int SAMPLE_BITS  = 24;
	localparam int COEF_BITS    = 18;
	localparam int FRAC_BITS    = 16;
	localparam int HALF_TAPS    = TAP_COUNT / 2;
	localparam int QUARTER_TAPS = TAP_COUNT / 4;
	localparam int ADDR_BITS    = $clog2(TAP_COUNT);
	localparam int FILL_BITS    = $clog2(TAP_COUNT + 1);
	localparam int PAIR_BITS    = $clog2(HALF_TAPS);
	localparam int DIFF_BITS    = SAMPLE_BITS + 1;
	localparam int PROD_BITS    = DIFF_BITS + COEF_BITS;
	localparam int ACC_BITS     = PROD_BITS + $clog2(HALF_TAPS);
	localparam int KIND_BITS    = 2;

	localparam logic [KIND_BITS-1:0] KIND_HILBERT = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_DERIV   = 2'd1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic                          first_sample;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] filtered_sample;
		logic                          saturated;
	} out_word_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic last_pair;
		logic pipe_busy;
		logic out_free;
	} sts_t;

endpackage

FILE: sv/fhd_ram.sv
// fhd_ram: generic memory, one write port and two registered read ports
// no dependencies

module fhd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

FILE: sv/fhd_coef_rom.sv
// fhd_coef_rom: hamming-windowed hilbert and derivative coefficients, folded half
// depends on fhd_pkg; table built at elaboration, registered read

module fhd_coef_rom (
	input  logic                                 clk,
	input  logic [fhd_pkg::PAIR_BITS-1:0]        pair,
	input  logic [fhd_pkg::KIND_BITS-1:0]        kind,
	output logic signed [fhd_pkg::COEF_BITS-1:0] coef_s1
);

	import fhd_pkg::*;

	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint PI_Q30  = 64'sd3373259426;

	// term * x^2 in q30
	function automatic longint sq_step(input longint term, input longint x);
		return term * x / Q30_ONE * x / Q30_ONE;
	endfunction

	// ten taylor terms of cos, divisors (2n-1)(2n)
	function automatic longint cos_series(input longint x);
		longint term;
		longint sum;
		term = sq_step(Q30_ONE, x) / 64'sd2;
		sum  = Q30_ONE - term;
		term = sq_step(term, x) / 64'sd12;
		sum  = sum + term;
		term = sq_step(term, x) / 64'sd30;
		sum  = sum - term;
		term = sq_step(term, x) / 64'sd56;
		sum  = sum + term;
		term = sq_step(term, x) / 64'sd90;
		sum  = sum - term;
		term = sq_step(term, x) / 64'sd132;
		sum  = sum + term;
		term = sq_step(term, x) / 64'sd182;
		sum  = sum - term;
		term = sq_step(term, x) / 64'sd240;
		sum  = sum + term;
		term = sq_step(term, x) / 64'sd306;
		sum  = sum - term;
		term = sq_step(term, x) / 64'sd380;
		sum  = sum + term;
		return sum;
	endfunction

	function automatic longint window_q30(input longint cosv);
		return (54 * Q30_ONE + 46 * cosv) / 100;
	endfunction

	logic signed [COEF_BITS-1:0] hilb_tab  [HALF_TAPS];
	logic signed [COEF_BITS-1:0] deriv_tab [HALF_TAPS];
	logic signed [COEF_BITS-1:0] coef_q;

	for (genvar g = 0; g < HALF_TAPS; g++) begin : g_tap
		localparam longint K = g + 1;
		// hilbert: cos(pi * 2k / taps), odd k only
		localparam longint HP0   = 2 * K;
		localparam bit     HFLIP = (2 * HP0 > TAP_COUNT);
		localparam longint HP    = HFLIP ? TAP_COUNT - HP0 : HP0;
		localparam longint HX    = PI_Q30 * HP / TAP_COUNT;
		localparam longint HCOS  = HFLIP ? -cos_series(HX) : cos_series(HX);
		localparam longint HW    = window_q30(HCOS);
		localparam longint HNUM  = 2 * HW * 65536;
		localparam longint HDEN  = K * PI_Q30;
		localparam longint HC    = (2 * HNUM + HDEN) / (2 * HDEN);
		localparam bit     HUSE  = (K % 2 == 1) && (K <= 2 * QUARTER_TAPS - 1);
		localparam longint HVAL  = HUSE ? HC : 64'sd0;
		// derivative: cos(pi * k / half), sign alternates
		localparam bit     DFLIP = (2 * K > HALF_TAPS);
		localparam longint DP    = DFLIP ? HALF_TAPS - K : K;
		localparam longint DX    = PI_Q30 * DP / HALF_TAPS;
		localparam longint DCOS  = DFLIP ? -cos_series(DX) : cos_series(DX);
		localparam longint DW    = window_q30(DCOS);
		localparam longint DDEN  = K * Q30_ONE;
		localparam longint DC    = (2 * DW * 65536 + DDEN) / (2 * DDEN);
		localparam longint DVAL  = (K % 2 == 1) ? -DC : DC;

		assign hilb_tab[g]  = HVAL[COEF_BITS-1:0];
		assign deriv_tab[g] = DVAL[COEF_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		coef_q <= (kind == KIND_HILBERT) ? hilb_tab[pair] : deriv_tab[pair];
	end

	assign coef_s1 = coef_q;

endmodule

FILE: sv/fhd_datapath.sv
// fhd_datapath: sample history, folded multiply-accumulate, rounding, clipping and result register
// depends on fhd_pkg, fhd_ram, fhd_coef_rom

module fhd_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fhd_pkg::in_word_t             sample_word,
	output logic                          result_valid,
	input  logic                          result_ready,
	output fhd_pkg::out_word_t            result_word,
	input  logic                          kind_we,
	input  logic [fhd_pkg::KIND_BITS-1:0] kind_data,
	input  fhd_pkg::cmd_t                 cmd,
	output fhd_pkg::sts_t                 sts
);

	import fhd_pkg::*;

	localparam int QW = ACC_BITS + 1 - FRAC_BITS;
	localparam logic signed [QW-1:0] SAT_MAX =
		QW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [QW-1:0] SAT_MIN = -SAT_MAX - QW'(1);

	logic [KIND_BITS-1:0]        kind_q;
	logic [ADDR_BITS-1:0]        wp_q;
	logic [FILL_BITS-1:0]        fill_q;
	logic [ADDR_BITS-1:0]        addr_a_q;
	logic [ADDR_BITS-1:0]        addr_b_q;
	logic [PAIR_BITS-1:0]        pair_q;
	logic                        v_s1, v_s2, v_s3;
	logic                        ok_a_s1, ok_b_s1;
	logic signed [SAMPLE_BITS-1:0] rd_a_s1, rd_b_s1;
	logic signed [COEF_BITS-1:0] coef_s1, coef_s2;
	logic signed [DIFF_BITS-1:0] diff_s2;
	logic signed [PROD_BITS-1:0] prod_s3;
	logic signed [ACC_BITS-1:0]  acc_q;
	logic                        out_valid_q;
	out_word_t                   out_word_q;

	logic [FILL_BITS-1:0]        fill_base;
	logic [FILL_BITS-1:0]        j_a, j_b;
	logic signed [SAMPLE_BITS-1:0] op_a, op_b;
	logic signed [ACC_BITS:0]    rnd_t;
	logic signed [QW-1:0]        rnd_q;
	logic                        sat_hi, sat_lo;

	fhd_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(TAP_COUNT)
	) u_hist (
		.clk     (clk),
		.we      (cmd.start),
		.waddr   (wp_q),
		.wdata   (sample_word.sample_in),
		.raddr_a (addr_a_q),
		.raddr_b (addr_b_q),
		.rdata_a (rd_a_s1),
		.rdata_b (rd_b_s1)
	);

	fhd_coef_rom u_rom (
		.clk     (clk),
		.pair    (pair_q),
		.kind    (kind_q),
		.coef_s1 (coef_s1)
	);

	assign fill_base = sample_word.first_sample ? '0 : fill_q;
	assign j_a = FILL_BITS'(HALF_TAPS + 1) + FILL_BITS'(pair_q);
	assign j_b = FILL_BITS'(HALF_TAPS - 1) - FILL_BITS'(pair_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_HILBERT;
			wp_q   <= '0;
			fill_q <= '0;
			pair_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
		end else begin
			if (kind_we) begin
				kind_q <= kind_data;
			end
			if (cmd.start) begin
				wp_q   <= (wp_q == ADDR_BITS'(TAP_COUNT - 1)) ? '0 : wp_q + 1'b1;
				fill_q <= (fill_base < FILL_BITS'(TAP_COUNT)) ? fill_base + 1'b1 : fill_base;
				pair_q <= '0;
			end else if (cmd.issue) begin
				pair_q <= pair_q + 1'b1;
			end
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// pair addresses walk outward from the centre tap
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			addr_a_q <= (wp_q >= ADDR_BITS'(HALF_TAPS + 1))
				? wp_q - ADDR_BITS'(HALF_TAPS + 1)
				: wp_q + ADDR_BITS'(TAP_COUNT - HALF_TAPS - 1);
			addr_b_q <= (wp_q >= ADDR_BITS'(HALF_TAPS - 1))
				? wp_q - ADDR_BITS'(HALF_TAPS - 1)
				: wp_q + ADDR_BITS'(TAP_COUNT - HALF_TAPS + 1);
		end else if (cmd.issue) begin
			addr_a_q <= (addr_a_q == '0) ? ADDR_BITS'(TAP_COUNT - 1) : addr_a_q - 1'b1;
			addr_b_q <= (addr_b_q == ADDR_BITS'(TAP_COUNT - 1)) ? '0 : addr_b_q + 1'b1;
		end
	end

	assign op_a = ok_a_s1 ? rd_a_s1 : '0;
	assign op_b = ok_b_s1 ? rd_b_s1 : '0;

	always_ff @(posedge clk) begin
		ok_a_s1 <= j_a < fill_q;
		ok_b_s1 <= j_b < fill_q;
		diff_s2 <= DIFF_BITS'(op_a) - DIFF_BITS'(op_b);
		coef_s2 <= coef_s1;
		prod_s3 <= coef_s2 * diff_s2;
		if (cmd.start) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + ACC_BITS'(prod_s3);
		end
	end

	// round half up, then clip
	assign rnd_t  = (ACC_BITS + 1)'(acc_q) + (ACC_BITS + 1)'(1 << (FRAC_BITS - 1));
	assign rnd_q  = rnd_t[ACC_BITS:FRAC_BITS];
	assign sat_hi = rnd_q > SAT_MAX;
	assign sat_lo = rnd_q < SAT_MIN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (kind_q != KIND_HILBERT && kind_q != KIND_DERIV) begin
				out_word_q.filtered_sample <= '0;
				out_word_q.saturated       <= 1'b0;
			end else begin
				out_word_q.filtered_sample <= sat_hi ? SAMPLE_BITS'(SAT_MAX)
					: sat_lo ? SAMPLE_BITS'(SAT_MIN) : rnd_q[SAMPLE_BITS-1:0];
				out_word_q.saturated       <= sat_hi | sat_lo;
			end
		end
	end

	assign result_valid  = out_valid_q;
	assign result_word   = out_word_q;
	assign sts.last_pair = (pair_q == PAIR_BITS'(HALF_TAPS - 1));
	assign sts.pipe_busy = v_s1 | v_s2 | v_s3;
	assign sts.out_free  = !out_valid_q || result_ready;

endmodule

FILE: sv/fhd_ctrl.sv
// fhd_ctrl: sequencer for accept, pair issue, pipeline drain and result load
// depends on fhd_pkg

module fhd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          sample_valid,
	output logic          sample_ready,
	input  fhd_pkg::sts_t sts,
	output fhd_pkg::cmd_t cmd
);

	import fhd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.start = sample_valid;
				if (sample_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (sts.last_pair) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy && sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign sample_ready = (state_q == ST_IDLE);

endmodule

FILE: sv/fir_hilbert_or_derivative_filter_unit.sv
// channel   | dir | handshake                   | word
// sample    | in  | sample_valid / sample_ready | in_word_t: sample_in, first_sample
// result    | out | result_valid / result_ready | out_word_t: filtered_sample, saturated
// kind cfg  | in  | kind_we                     | kind_data, transform kind
//
// per word: accept, 100 folded tap pairs through the single mac, three pipeline
// stages to drain, result register load; the next word waits for that load
// the next word is taken while a result still waits in its register
// a stalled result holds the sequencer in drain until the register frees
// reset clears history fill, write slot, transform kind and all valid flags
// depends on fhd_pkg, fhd_ctrl, fhd_datapath

module fir_hilbert_or_derivative_filter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  fhd_pkg::in_word_t             sample_word,
	output logic                          result_valid,
	input  logic                          result_ready,
	output fhd_pkg::out_word_t            result_word,
	input  logic                          kind_we,
	input  logic [fhd_pkg::KIND_BITS-1:0] kind_data
);

	import fhd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fhd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	fhd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_word  (sample_word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word),
		.kind_we      (kind_we),
		.kind_data    (kind_data),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

FILE: sv/fhd_checker.sv
// fhd_checker: port-level checks on the fir filter unit, bound to the top level
// depends on fhd_pkg and fir_hilbert_or_derivative_filter_unit

module fhd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_ready,
	input fhd_pkg::in_word_t  sample_word,
	input logic               result_valid,
	input logic               result_ready,
	input fhd_pkg::out_word_t result_word
);

	import fhd_pkg::*;

	localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX =
		SAMPLE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = -OUT_MAX - SAMPLE_BITS'(1);

	// stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_word))
		else $error("result word changed while stalled");

	// one word in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("second sample word taken during processing");

	// no result straight after a sample word
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready && !result_valid |=> !result_valid)
		else $error("result appeared one cycle after accept");

	// clip flag only at the rails
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.saturated |->
			result_word.filtered_sample == OUT_MAX ||
			result_word.filtered_sample == OUT_MIN)
		else $error("saturated flag without a rail value");

	// waiting sample word holds
	a_sample_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_ready |=> sample_valid && $stable(sample_word))
		else $error("sample word changed while waiting");

endmodule

bind fir_hilbert_or_derivative_filter_unit fhd_checker u_fhd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.sample_word  (sample_word),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_word  (result_word)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench for fir_hilbert_or_derivative_filter_unit: directed, saturation, back-pressure
// and random record tests, all checked against an in-bench fixed-point filter model
// depends on fhd_pkg and the filter unit rtl

module testbench;
	import fhd_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 600;
	localparam int MAX_SHOWN   = 10;
	localparam logic [KIND_BITS-1:0] KIND_ZERO  = 2'd2;
	localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam longint SAT_MAX = SAMPLE_HI;
	localparam longint SAT_MIN = SAMPLE_LO;
	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint PI_Q30  = 64'sd3373259426;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_ready;
	in_word_t             sample_word = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	out_word_t            result_word;
	logic                 kind_we = 1'b0;
	logic [KIND_BITS-1:0] kind_data = '0;

	// filter model state
	longint               hilbert_coef [TAP_COUNT];
	longint               deriv_coef [TAP_COUNT];
	longint               history [TAP_COUNT];
	int                   history_fill = 0;
	int                   write_slot = 0;
	logic [KIND_BITS-1:0] kind_now = KIND_HILBERT;

	out_word_t            pending_filtered [$];
	int                   mismatch_count = 0;
	int                   words_sent = 0;
	int                   results_checked = 0;
	int                   clipped_seen = 0;
	int                   cycle_count = 0;
	bit                   hold_request = 1'b0;
	bit                   no_idle = 1'b0;

	fir_hilbert_or_derivative_filter_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_word(sample_word),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_word(result_word),
		.kind_we(kind_we),
		.kind_data(kind_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// 0.54 + 0.46 * cos(pi * p / q) in q30, taylor series as the coefficient rom is built
	function automatic longint hamming_q30(longint p, longint q);
		longint x, term, total;
		bit flip;
		int n;
		flip = 1'b0;
		if (2 * p > q) begin
			p = q - p;
			flip = 1'b1;
		end
		x = PI_Q30 * p / q;
		term = Q30_ONE;
		total = Q30_ONE;
		for (n = 1; n <= 10; n++) begin
			term = term * x / Q30_ONE;
			term = term * x / Q30_ONE;
			term = term / ((2 * n - 1) * (2 * n));
			if (n & 1)
				total -= term;
			else
				total += term;
		end
		if (flip)
			total = -total;
		return (54 * Q30_ONE + 46 * total) / 100;
	endfunction

	initial begin : coef_rom
		longint w, den, c, odd;
		int i;
		for (i = 0; i < TAP_COUNT; i++) begin
			hilbert_coef[i] = 0;
			deriv_coef[i] = 0;
		end
		for (i = 1; i <= QUARTER_TAPS; i++) begin
			odd = 2 * i - 1;
			w = hamming_q30(2 * odd, TAP_COUNT);
			den = odd * PI_Q30;
			c = (4 * w * 65536 + den) / (2 * den);
			if (HALF_TAPS + odd < TAP_COUNT)
				hilbert_coef[HALF_TAPS + odd] = c;
			hilbert_coef[HALF_TAPS - odd] = -c;
		end
		for (i = 1; i <= HALF_TAPS; i++) begin
			w = hamming_q30(i, HALF_TAPS);
			den = longint'(i) * Q30_ONE;
			c = (2 * w * 65536 + den) / (2 * den);
			if (i & 1)
				c = -c;
			if (HALF_TAPS + i < TAP_COUNT)
				deriv_coef[HALF_TAPS + i] = c;
			deriv_coef[HALF_TAPS - i] = -c;
		end
	end

	// takes one sample word into the model history and returns the filtered word
	function automatic out_word_t fir_next_output(in_word_t word);
		longint acc, rounded, coef;
		int newest, j;
		out_word_t res;
		if (word.first_sample)
			history_fill = 0;
		newest = write_slot;
		history[newest] = longint'($signed(word.sample_in));
		write_slot = (newest + 1) % TAP_COUNT;
		if (history_fill < TAP_COUNT)
			history_fill++;
		res = '0;
		if (kind_now == KIND_HILBERT || kind_now == KIND_DERIV) begin
			acc = 0;
			for (j = 0; j < history_fill; j++) begin
				coef = (kind_now == KIND_HILBERT) ? hilbert_coef[j] : deriv_coef[j];
				acc += coef * history[(newest + TAP_COUNT - j) % TAP_COUNT];
			end
			// round half up then floor
			rounded = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			if (rounded > SAT_MAX) begin
				res.filtered_sample = SAMPLE_HI;
				res.saturated = 1'b1;
			end else if (rounded < SAT_MIN) begin
				res.filtered_sample = SAMPLE_LO;
				res.saturated = 1'b1;
			end else begin
				res.filtered_sample = rounded[SAMPLE_BITS-1:0];
			end
		end
		return res;
	endfunction

	function automatic int draw_gap();
		if (no_idle)
			return 0;
		return $urandom_range(0, 15);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return SAMPLE_HI;
			1: return SAMPLE_LO;
			2, 3: return SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic void report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= MAX_SHOWN)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic first);
		in_word_t word;
		int gap;
		word.sample_in = value;
		word.first_sample = first;
		gap = draw_gap();
		if (gap > 0) begin
			@(negedge clk);
			sample_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		sample_word <= word;
		do @(posedge clk); while (sample_ready !== 1'b1);
		pending_filtered.push_back(fir_next_output(word));
		words_sent++;
	endtask

	task automatic drain(input int settle);
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending_filtered.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_kind(input logic [KIND_BITS-1:0] kind);
		drain(8);
		@(negedge clk);
		kind_we <= 1'b1;
		kind_data <= kind;
		@(negedge clk);
		kind_we <= 1'b0;
		kind_now = kind;
	endtask

	task automatic test_directed();
		logic [KIND_BITS-1:0] kinds [4] = '{KIND_HILBERT, KIND_DERIV, KIND_ZERO, KIND_SPARE};
		int k;
		for (k = 0; k < 4; k++) begin
			// first pass runs on the kind left by reset
			if (k != 0)
				set_kind(kinds[k]);
			send_sample(SAMPLE_HI, 1'b1);
			send_sample(SAMPLE_LO, 1'b0);
			send_sample('0, 1'b0);
			send_sample('1, 1'b0);
			send_sample(SAMPLE_HI, 1'b1);
			send_sample(SAMPLE_BITS'(1), 1'b0);
		end
	endtask

	// full records whose signs follow the taps, so the last sum clips
	task automatic test_saturation();
		longint coef;
		int polarity, p;
		logic [KIND_BITS-1:0] kind;
		logic signed [SAMPLE_BITS-1:0] value;
		for (polarity = 0; polarity < 2; polarity++) begin
			kind = (polarity == 0) ? KIND_HILBERT : KIND_DERIV;
			set_kind(kind);
			no_idle = (polarity == 0);
			for (p = 0; p < TAP_COUNT; p++) begin
				coef = (kind == KIND_HILBERT) ? hilbert_coef[TAP_COUNT-1-p]
				                              : deriv_coef[TAP_COUNT-1-p];
				if (coef == 0)
					value = pick_sample();
				else if ((coef > 0) == (polarity == 0))
					value = SAMPLE_HI;
				else
					value = SAMPLE_LO;
				send_sample(value, p == 0);
			end
		end
		no_idle = 1'b0;
	endtask

	task automatic test_backpressure();
		int n;
		set_kind(KIND_DERIV);
		hold_request = 1'b1;
		no_idle = 1'b1;
		for (n = 0; n < 12; n++)
			send_sample(pick_sample(), n == 0);
		no_idle = 1'b0;
	endtask

	task automatic test_random();
		logic [KIND_BITS-1:0] order [6] = '{KIND_HILBERT, KIND_DERIV, KIND_SPARE,
		                                    KIND_ZERO, KIND_HILBERT, KIND_DERIV};
		int budget [6] = '{140, 140, 40, 40, 60, 60};
		int phase, sent, len, n, pick;
		bit broken;
		for (phase = 0; phase < 6; phase++) begin
			set_kind(order[phase]);
			sent = 0;
			while (sent < budget[phase]) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					len = $urandom_range(1, 12);
				else if (pick < 9)
					len = $urandom_range(13, 80);
				else
					len = $urandom_range(150, 260);
				// some records carry on the old history instead of starting afresh
				broken = ($urandom_range(0, 7) == 0);
				for (n = 0; n < len; n++)
					send_sample(pick_sample(), (n == 0 && !broken) || ($urandom_range(0, 63) == 0));
				sent += len;
			end
		end
	endtask

	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				stall = HOLD_CYCLES;
				hold_request = 1'b0;
			end else begin
				stall = draw_gap();
			end
			repeat (stall) begin
				@(negedge clk);
				result_ready <= 1'b0;
			end
			@(negedge clk);
			result_ready <= 1'b1;
			do @(posedge clk); while (result_valid !== 1'b1);
		end
	end

	always @(posedge clk) begin : check_result
		out_word_t want;
		if (arst_n && result_valid === 1'b1 && result_ready === 1'b1) begin
			if (pending_filtered.size() == 0) begin
				report_mismatch($sformatf("unexpected word sample %0d sat %0b",
					result_word.filtered_sample, result_word.saturated));
			end else begin
				want = pending_filtered.pop_front();
				results_checked++;
				if (result_word.filtered_sample !== want.filtered_sample)
					report_mismatch($sformatf("word %0d filtered_sample expected %0d got %0d",
						results_checked, want.filtered_sample, result_word.filtered_sample));
				if (result_word.saturated !== want.saturated)
					report_mismatch($sformatf("word %0d saturated expected %0b got %0b",
						results_checked, want.saturated, result_word.saturated));
				if (want.saturated)
					clipped_seen++;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run stopped after %0d cycles, %0d words still awaited",
			cycle_count, pending_filtered.size());
		$display("TB_ERROR");
		$finish;
	end

	initial begin : run
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_saturation();
		test_backpressure();
		test_random();
		drain(120);
		$display("%0d sample words sent, %0d results checked, %0d clipped, %0d mismatches",
			words_sent, results_checked, clipped_seen, mismatch_count);
		$display("all four transform kinds, records up to 260 words, %0d-cycle output stall",
			HOLD_CYCLES);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
